// ----- hdl/rpu_pkg.sv -----
package rpu_pkg;

    typedef enum logic [4:0] {
        KIND_NONE      = 5'd0,
        KIND_ADDR64    = 5'd1,
        KIND_ADDR32    = 5'd2,
        KIND_ADDR16    = 5'd3,
        KIND_HI        = 5'd4,
        KIND_HA        = 5'd5,
        KIND_HIGHER    = 5'd6,
        KIND_HIGHERA   = 5'd7,
        KIND_HIGHEST   = 5'd8,
        KIND_HIGHESTA  = 5'd9,
        KIND_DS        = 5'd10,
        KIND_ADDR24    = 5'd11,
        KIND_ADDR14    = 5'd12,
        KIND_BR_TAKEN  = 5'd13,
        KIND_BR_NTAKEN = 5'd14,
        KIND_REL24     = 5'd15,
        KIND_REL32     = 5'd16,
        KIND_REL64     = 5'd17,
        KIND_RELATIVE  = 5'd18
    } kind_t;

    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0000_8000;
    localparam logic [31:0] DS_MASK    = 32'h0000_fffc;
    localparam logic [31:0] B24_MASK   = 32'h03ff_fffc;
    localparam logic [31:0] B24_KEEP   = 32'hfc00_0003;
    localparam logic [31:0] B14_KEEP   = 32'hffff_0003;
    localparam logic [31:0] BR_KEEP    = 32'hffdf_0003;
    localparam int          HINT_POS   = 21;

    localparam logic [3:0] BYTES_NONE = 4'd0;
    localparam logic [3:0] BYTES_HALF = 4'd2;
    localparam logic [3:0] BYTES_WORD = 4'd4;
    localparam logic [3:0] BYTES_DBL  = 4'd8;

    typedef struct packed {
        logic [63:0] contents;
        logic [3:0]  bytes;
        logic        failed;
    } result_t;

endpackage

// ----- hdl/rpu_patch_calc.sv -----
module rpu_patch_calc (
    input  logic [4:0]      kind,
    input  logic [63:0]     value,
    input  logic [63:0]     place,
    input  logic [31:0]     old,
    output rpu_pkg::result_t res
);
    import rpu_pkg::*;

    logic [63:0] rounded;
    logic [63:0] pcrel;
    logic [31:0] br_word;

    assign rounded = value + ROUND_HALF;
    assign pcrel   = value - place;

    always_comb
    begin
        br_word = (value[31:0] & DS_MASK) | (old & BR_KEEP);
        // hint bit follows the sign of V, flipped for the taken kind
        br_word[HINT_POS] = (kind_t'(kind) == KIND_BR_TAKEN) ^ value[63];
    end

    always_comb
    begin
        res.contents = '0;
        res.bytes    = BYTES_NONE;
        res.failed   = 1'b0;
        case (kind_t'(kind))
            KIND_NONE:
            begin
                res.contents = '0;
            end
            KIND_ADDR64:
            begin
                res.contents = value;
                res.bytes    = BYTES_DBL;
            end
            KIND_ADDR32:
            begin
                res.contents = {32'd0, value[31:0]};
                res.bytes    = BYTES_WORD;
            end
            KIND_ADDR16:
            begin
                res.contents = {48'd0, value[15:0]};
                res.bytes    = BYTES_HALF;
            end
            KIND_HI:
            begin
                res.contents = {48'd0, value[31:16]};
                res.bytes    = BYTES_HALF;
            end
            KIND_HA:
            begin
                res.contents = {48'd0, rounded[31:16]};
                res.bytes    = BYTES_HALF;
            end
            KIND_HIGHER:
            begin
                res.contents = {48'd0, value[47:32]};
                res.bytes    = BYTES_HALF;
            end
            KIND_HIGHERA:
            begin
                res.contents = {48'd0, rounded[47:32]};
                res.bytes    = BYTES_HALF;
            end
            KIND_HIGHEST:
            begin
                res.contents = {48'd0, value[63:48]};
                res.bytes    = BYTES_HALF;
            end
            KIND_HIGHESTA:
            begin
                res.contents = {48'd0, rounded[63:48]};
                res.bytes    = BYTES_HALF;
            end
            KIND_DS:
            begin
                res.contents = {48'd0, value[15:2], old[1:0]};
                res.bytes    = BYTES_HALF;
            end
            KIND_ADDR24:
            begin
                res.contents = {32'd0, (value[31:0] & B24_MASK) | (old & B24_KEEP)};
                res.bytes    = BYTES_WORD;
            end
            KIND_ADDR14:
            begin
                res.contents = {32'd0, (value[31:0] & DS_MASK) | (old & B14_KEEP)};
                res.bytes    = BYTES_WORD;
            end
            KIND_BR_TAKEN, KIND_BR_NTAKEN:
            begin
                res.contents = {32'd0, br_word};
                res.bytes    = BYTES_WORD;
            end
            KIND_REL24:
            begin
                res.contents = {32'd0, (pcrel[31:0] & B24_MASK) | (old & B24_KEEP)};
                res.bytes    = BYTES_WORD;
            end
            KIND_REL32:
            begin
                res.contents = {32'd0, pcrel[31:0]};
                res.bytes    = BYTES_WORD;
            end
            KIND_REL64:
            begin
                res.contents = pcrel;
                res.bytes    = BYTES_DBL;
            end
            default:
            begin
                res.failed = 1'b1;
            end
        endcase
    end

endmodule

// ----- hdl/ppc64_relocation_patch_unit.sv -----
// Channel   Handshake         Ports
// -------   ---------------   ------------------------------------------------
// command   start & !busy     reloc_kind symbol_value addend place_address
//                             old_contents
// result    done (1 cycle)    new_contents write_bytes failed
//
// One word per cycle. done rises once the word has passed an input register
// (holding symbol plus addend) and a result register.
// busy is held low; a new word is taken every cycle.
// Reset clears only the valid flags; payload registers are not reset.
// The receiver cannot stall: each result shows for exactly one cycle.
module ppc64_relocation_patch_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  reloc_kind,
    input  logic [63:0] symbol_value,
    input  logic [63:0] addend,
    input  logic [63:0] place_address,
    input  logic [31:0] old_contents,
    output logic        done,
    output logic [63:0] new_contents,
    output logic [3:0]  write_bytes,
    output logic        failed
);
    import rpu_pkg::*;

    logic        in_valid_reg;
    logic [4:0]  kind_reg;
    logic [63:0] value_reg;
    logic [63:0] place_reg;
    logic [31:0] old_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg  <= reloc_kind;
            value_reg <= symbol_value + addend;
            place_reg <= place_address;
            old_reg   <= old_contents;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    rpu_patch_calc u_calc (
        .kind  (kind_reg),
        .value (value_reg),
        .place (place_reg),
        .old   (old_reg),
        .res   (result_next)
    );

    assign done         = out_valid_reg;
    assign new_contents = result_reg.contents;
    assign write_bytes  = result_reg.bytes;
    assign failed       = result_reg.failed;

endmodule

// ----- bench/ppc64_relocation_patch_unit_test.sv -----
`timescale 1ns / 1ps

module ppc64_relocation_patch_unit_test;

    import rpu_pkg::*;

    localparam logic [4:0] KIND_FIRST_UNKNOWN = 5'd19;
    localparam logic [4:0] KIND_LAST_UNKNOWN  = 5'd31;
    localparam int         WORD_COUNT         = 1650;
    localparam int         CYCLE_LIMIT        = 200000;
    localparam int         DRAIN_CYCLES       = 6;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  reloc_kind;
    logic [63:0] symbol_value;
    logic [63:0] addend;
    logic [63:0] place_address;
    logic [31:0] old_contents;
    logic        done;
    logic [63:0] new_contents;
    logic [3:0]  write_bytes;
    logic        failed;

    int unsigned cycle_count = 0;

    class patch_scoreboard;
        result_t     pending_patches[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function result_t patched_word(logic [4:0] kind, logic [63:0] sym, logic [63:0] add,
                                       logic [63:0] place, logic [31:0] old_w);
            logic [63:0] v;
            logic [63:0] rounded;
            logic [63:0] pcrel;
            logic [31:0] w;
            result_t     r;
            v         = sym + add;
            rounded   = v + ROUND_HALF;
            pcrel     = v - place;
            r.contents = '0;
            r.bytes    = BYTES_NONE;
            r.failed   = 1'b0;
            case (kind)
                KIND_NONE:
                begin
                end
                KIND_ADDR64:
                begin
                    r.contents = v;
                    r.bytes    = BYTES_DBL;
                end
                KIND_ADDR32:
                begin
                    r.contents = {32'b0, v[31:0]};
                    r.bytes    = BYTES_WORD;
                end
                KIND_ADDR16:
                begin
                    r.contents = {48'b0, v[15:0]};
                    r.bytes    = BYTES_HALF;
                end
                KIND_HI:
                begin
                    r.contents = {48'b0, v[31:16]};
                    r.bytes    = BYTES_HALF;
                end
                KIND_HA:
                begin
                    r.contents = {48'b0, rounded[31:16]};
                    r.bytes    = BYTES_HALF;
                end
                KIND_HIGHER:
                begin
                    r.contents = {48'b0, v[47:32]};
                    r.bytes    = BYTES_HALF;
                end
                KIND_HIGHERA:
                begin
                    r.contents = {48'b0, rounded[47:32]};
                    r.bytes    = BYTES_HALF;
                end
                KIND_HIGHEST:
                begin
                    r.contents = {48'b0, v[63:48]};
                    r.bytes    = BYTES_HALF;
                end
                KIND_HIGHESTA:
                begin
                    r.contents = {48'b0, rounded[63:48]};
                    r.bytes    = BYTES_HALF;
                end
                KIND_DS:
                begin
                    r.contents = {32'b0, (v[31:0] & DS_MASK) | {30'b0, old_w[1:0]}};
                    r.bytes    = BYTES_HALF;
                end
                KIND_ADDR24:
                begin
                    r.contents = {32'b0, (v[31:0] & B24_MASK) | (old_w & B24_KEEP)};
                    r.bytes    = BYTES_WORD;
                end
                KIND_ADDR14:
                begin
                    r.contents = {32'b0, (v[31:0] & DS_MASK) | (old_w & B14_KEEP)};
                    r.bytes    = BYTES_WORD;
                end
                KIND_BR_TAKEN, KIND_BR_NTAKEN:
                begin
                    // hint bit flips when the target is negative
                    w           = (v[31:0] & DS_MASK) | (old_w & BR_KEEP);
                    w[HINT_POS] = (kind == KIND_BR_TAKEN) ^ v[63];
                    r.contents  = {32'b0, w};
                    r.bytes     = BYTES_WORD;
                end
                KIND_REL24:
                begin
                    r.contents = {32'b0, (pcrel[31:0] & B24_MASK) | (old_w & B24_KEEP)};
                    r.bytes    = BYTES_WORD;
                end
                KIND_REL32:
                begin
                    r.contents = {32'b0, pcrel[31:0]};
                    r.bytes    = BYTES_WORD;
                end
                KIND_REL64:
                begin
                    r.contents = pcrel;
                    r.bytes    = BYTES_DBL;
                end
                default:
                begin
                    r.failed = 1'b1;
                end
            endcase
            return r;
        endfunction

        function void note_word(logic [4:0] kind, logic [63:0] sym, logic [63:0] add,
                                logic [63:0] place, logic [31:0] old_w);
            pending_patches.push_back(patched_word(kind, sym, add, place, old_w));
        endfunction

        function void check_word(logic [63:0] contents, logic [3:0] bytes, logic fail);
            result_t e;
            if (pending_patches.size() == 0)
            begin
                $display("%0t: unexpected result contents %h bytes %0d failed %b",
                         $time, contents, bytes, fail);
                mismatches++;
                return;
            end
            e = pending_patches.pop_front();
            if (contents !== e.contents)
            begin
                $display("%0t: new_contents expected %h actual %h", $time, e.contents, contents);
                mismatches++;
            end
            if (bytes !== e.bytes)
            begin
                $display("%0t: write_bytes expected %0d actual %0d", $time, e.bytes, bytes);
                mismatches++;
            end
            if (fail !== e.failed)
            begin
                $display("%0t: failed expected %b actual %b", $time, e.failed, fail);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_patches.size();
        endfunction
    endclass

    patch_scoreboard board;

    ppc64_relocation_patch_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .reloc_kind    (reloc_kind),
        .symbol_value  (symbol_value),
        .addend        (addend),
        .place_address (place_address),
        .old_contents  (old_contents),
        .done          (done),
        .new_contents  (new_contents),
        .write_bytes   (write_bytes),
        .failed        (failed)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_word(reloc_kind, symbol_value, addend, place_address, old_contents);
        if (rst_n && done)
            board.check_word(new_contents, write_bytes, failed);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ppc64_relocation_patch_unit verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [4:0] kind, input logic [63:0] sym,
                             input logic [63:0] add, input logic [63:0] place,
                             input logic [31:0] old_w);
        start         <= 1'b1;
        reloc_kind    <= kind;
        symbol_value  <= sym;
        addend        <= add;
        place_address <= place;
        old_contents  <= old_w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] pick_address();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: a = '0;
            1: a = '1;
            2: a[15:0] = 16'h8000 - 16'($urandom_range(0, 2));
            3: a[47:0] = 48'hffff_ffff_8000 - 48'($urandom_range(0, 2));
            4: a = 64'($urandom_range(0, 255));
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [4:0] pick_kind();
        if ($urandom_range(0, 99) < 8)
            return 5'($urandom_range(KIND_FIRST_UNKNOWN, KIND_LAST_UNKNOWN));
        return 5'($urandom_range(KIND_NONE, KIND_RELATIVE));
    endfunction

    initial
    begin
        int sent;
        int burst;
        clk           = 1'b0;
        board         = new();
        rst_n         <= 1'b0;
        start         <= 1'b0;
        reloc_kind    <= KIND_NONE;
        symbol_value  <= '0;
        addend        <= '0;
        place_address <= '0;
        old_contents  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_NONE, '1, '1, '1, '1);
        send_word(KIND_ADDR64, '1, 64'd1, '0, '0);
        send_word(KIND_ADDR64, '1, '1, '1, '1);
        send_word(KIND_ADDR32, 64'h1234_5678_9abc_def0, 64'h10, '0, '1);
        send_word(KIND_ADDR16, '1, '0, '0, '1);
        send_word(KIND_HI, 64'h0000_0000_ffff_0000, '0, '0, '1);
        send_word(KIND_HA, 64'h0000_0000_1234_7fff, 64'd1, '0, '0);
        send_word(KIND_HA, 64'h0000_0000_1234_7fff, '0, '0, '0);
        send_word(KIND_HIGHER, 64'h0000_ffff_0000_0000, '0, '0, '0);
        send_word(KIND_HIGHERA, 64'h0000_fffe_ffff_8000, '0, '0, '0);
        send_word(KIND_HIGHEST, 64'hffff_0000_0000_0000, '0, '0, '0);
        send_word(KIND_HIGHESTA, 64'hffff_ffff_ffff_8000, '0, '0, '0);
        send_word(KIND_DS, '1, '0, '0, '1);
        send_word(KIND_DS, '1, '0, '0, '0);
        send_word(KIND_ADDR24, '1, '0, '0, '1);
        send_word(KIND_ADDR14, '1, '0, '0, '1);
        send_word(KIND_BR_TAKEN, 64'h0000_0000_0000_1234, '0, '0, '1);
        send_word(KIND_BR_TAKEN, 64'h8000_0000_0000_1234, '0, '0, '0);
        send_word(KIND_BR_NTAKEN, 64'h0000_0000_0000_1234, '0, '0, '0);
        send_word(KIND_BR_NTAKEN, 64'h8000_0000_0000_1234, '0, '0, '1);
        send_word(KIND_REL24, 64'h100, '0, 64'h200, '1);
        send_word(KIND_REL32, '0, '0, '1, '0);
        send_word(KIND_REL64, '0, '0, '1, '0);
        send_word(KIND_RELATIVE, '1, '1, '1, '1);
        send_word(KIND_FIRST_UNKNOWN, '1, '1, '1, '1);
        send_word(KIND_LAST_UNKNOWN, '0, '0, '0, '0);

        // bursts with random gaps; some long stretches run back to back
        sent = 0;
        while (sent < WORD_COUNT)
        begin
            burst = $urandom_range(0, 9) == 0 ? $urandom_range(50, 120) : $urandom_range(1, 12);
            repeat (burst)
            begin
                send_word(pick_kind(), pick_address(), pick_address(), pick_address(),
                          $urandom);
                sent++;
            end
            hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
        end
        start <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("ppc64_relocation_patch_unit verification clean");
        else
            $display("ppc64_relocation_patch_unit verification failed");
        $finish;
    end

endmodule
